FILE: hw/rtl/sumcs_pkg.sv
`default_nettype none

package sumcs_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = 3;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;
  localparam int NEXT_PC_W = 11;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_HALT     = 3'd1,
    ST_DIV0     = 3'd2,
    ST_BAD      = 3'd3,
    ST_MAPFAIL  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_CMOV     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_STORE    = 4'd2,
    OP_ADD      = 4'd3,
    OP_MUL      = 4'd4,
    OP_DIV      = 4'd5,
    OP_NAND     = 4'd6,
    OP_HALT     = 4'd7,
    OP_MAP      = 4'd8,
    OP_UNMAP    = 4'd9,
    OP_OUT      = 4'd10,
    OP_IN       = 4'd11,
    OP_LOADPROG = 4'd12,
    OP_LOADIMM  = 4'd13
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RDBC,
    S_RDA,
    S_SEG,
    S_EXEC,
    S_LOAD,
    S_DIV,
    S_FILL,
    S_COPY,
    S_JUMP,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_START,
    CMD_RDBC,
    CMD_RDA,
    CMD_SEG,
    CMD_EXEC,
    CMD_LOAD,
    CMD_DIV,
    CMD_FILL,
    CMD_COPY,
    CMD_JUMP,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [2:0] {
    NX_DONE,
    NX_LOAD,
    NX_DIV,
    NX_FILL,
    NX_COPY,
    NX_JUMP
  } nx_e;

  typedef struct packed {
    logic start_run;
    nx_e  exec_next;
    logic loop_last;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/segmented_um_cpu_step_top.sv
// Mode 0 beats (program append) pass from acceptance through the start state to the done state.
// Mode 1 beats run fetch, two register-file reads, segment lookup and execute in turn.
// Loads add a memory read, divide produces one quotient bit per cycle, map zeroes one word
// per cycle, and load program copies one word per cycle before its jump.
// One instruction is in flight at a time; the next beat is taken while a result waits.
// Reset is asynchronous active low and leaves segment 0 empty, registers zero, pc zero.
`default_nettype none

module segmented_um_cpu_step_top #(
  parameter int SEG_COUNT = 64,
  parameter int SEG_WORDS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // program_word[31:0], in_byte[39:32], in_eof[40], zero[47:41]
  input  logic [sumcs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // mode[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_valid[0], out_byte[8:1], input_taken[9], status[12:10], next_pc[23:13]
  output logic [sumcs_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  sumcs_pkg::cmd_e     cmd;
  sumcs_pkg::dp_stat_t stat;

  sumcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sumcs_dp #(
    .SEG_COUNT (SEG_COUNT),
    .SEG_WORDS (SEG_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_mode_i   (s_axis_tuser),
    .in_word_i   (s_axis_tdata[31:0]),
    .in_byte_i   (s_axis_tdata[39:32]),
    .in_eof_i    (s_axis_tdata[40]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sumcs_ctrl.sv
`default_nettype none

module sumcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sumcs_pkg::dp_stat_t stat_i,
  output sumcs_pkg::cmd_e     cmd_o
);

  sumcs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sumcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = sumcs_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      sumcs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = sumcs_pkg::CMD_ACCEPT;
          state_d = sumcs_pkg::S_START;
        end
      end
      sumcs_pkg::S_START: begin
        cmd_o   = sumcs_pkg::CMD_START;
        state_d = stat_i.start_run ? sumcs_pkg::S_RDBC : sumcs_pkg::S_DONE;
      end
      sumcs_pkg::S_RDBC: begin
        cmd_o   = sumcs_pkg::CMD_RDBC;
        state_d = sumcs_pkg::S_RDA;
      end
      sumcs_pkg::S_RDA: begin
        cmd_o   = sumcs_pkg::CMD_RDA;
        state_d = sumcs_pkg::S_SEG;
      end
      sumcs_pkg::S_SEG: begin
        cmd_o   = sumcs_pkg::CMD_SEG;
        state_d = sumcs_pkg::S_EXEC;
      end
      sumcs_pkg::S_EXEC: begin
        cmd_o = sumcs_pkg::CMD_EXEC;
        case (stat_i.exec_next)
          sumcs_pkg::NX_LOAD: state_d = sumcs_pkg::S_LOAD;
          sumcs_pkg::NX_DIV:  state_d = sumcs_pkg::S_DIV;
          sumcs_pkg::NX_FILL: state_d = sumcs_pkg::S_FILL;
          sumcs_pkg::NX_COPY: state_d = sumcs_pkg::S_COPY;
          sumcs_pkg::NX_JUMP: state_d = sumcs_pkg::S_JUMP;
          default:            state_d = sumcs_pkg::S_DONE;
        endcase
      end
      sumcs_pkg::S_LOAD: begin
        cmd_o   = sumcs_pkg::CMD_LOAD;
        state_d = sumcs_pkg::S_DONE;
      end
      sumcs_pkg::S_DIV: begin
        cmd_o = sumcs_pkg::CMD_DIV;
        if (stat_i.div_last) begin
          state_d = sumcs_pkg::S_DONE;
        end
      end
      sumcs_pkg::S_FILL: begin
        cmd_o = sumcs_pkg::CMD_FILL;
        if (stat_i.loop_last) begin
          state_d = sumcs_pkg::S_DONE;
        end
      end
      sumcs_pkg::S_COPY: begin
        cmd_o = sumcs_pkg::CMD_COPY;
        if (stat_i.loop_last) begin
          state_d = sumcs_pkg::S_JUMP;
        end
      end
      sumcs_pkg::S_JUMP: begin
        cmd_o   = sumcs_pkg::CMD_JUMP;
        state_d = sumcs_pkg::S_DONE;
      end
      sumcs_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o   = sumcs_pkg::CMD_EMIT;
          state_d = sumcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sumcs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sumcs_dp.sv
`default_nettype none

module sumcs_dp #(
  parameter int SEG_COUNT = 64,
  parameter int SEG_WORDS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sumcs_pkg::cmd_e                     cmd_i,
  output sumcs_pkg::dp_stat_t                 stat_o,
  input  logic                                in_mode_i,
  input  logic [sumcs_pkg::WORD_W-1:0]        in_word_i,
  input  logic [7:0]                          in_byte_i,
  input  logic                                in_eof_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [sumcs_pkg::M_TDATA_W-1:0]     out_data_o
);

  localparam int SIDW  = $clog2(SEG_COUNT);
  localparam int LENW  = $clog2(SEG_WORDS + 1);
  localparam int CNTW  = $clog2(SEG_COUNT + 1);
  localparam int DEPTH = SEG_COUNT * SEG_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int W     = sumcs_pkg::WORD_W;
  localparam int RAW   = sumcs_pkg::REG_AW;

  function automatic logic [AW-1:0] slot_addr(input logic [SIDW-1:0] seg,
                                               input logic [LENW-1:0] off);
    return AW'(seg) * AW'(SEG_WORDS) + AW'(off);
  endfunction

  logic                   mode_q;
  logic [W-1:0]           pword_q;
  logic [7:0]             inb_q;
  logic                   eof_q;
  sumcs_pkg::status_e     status_q;
  logic [LENW-1:0]        pc_q;
  logic [LENW-1:0]        len0_q;
  logic [W-1:0]           ir_q;
  logic [W-1:0]           ra_q, rb_q, rc_q;
  logic                   sel_is0_q, sel_inr_q, sel_vld_q;
  logic [SIDW-1:0]        fq_head_q;
  logic [CNTW-1:0]        fq_cnt_q;
  logic [CNTW-1:0]        nu_q;
  logic [SIDW-1:0]        map_id_q;
  logic [SIDW-1:0]        src_q;
  logic [LENW-1:0]        lp_q, lp_end_q;
  logic [W-1:0]           div_rem_q, div_quo_q;
  logic [sumcs_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic                   emit_q, taken_q;
  logic [7:0]             obyte_q;
  logic                   out_vld_q;
  logic [sumcs_pkg::M_TDATA_W-1:0] out_data_q;

  logic [W-1:0]           rf_mem [sumcs_pkg::NUM_REGS];
  logic [sumcs_pkg::NUM_REGS-1:0] rf_vld_q;
  logic [W-1:0]           rf_q0, rf_q1;
  logic [RAW-1:0]         rf_ra0, rf_ra1, rf_wa;
  logic                   rf_we;
  logic [W-1:0]           rf_wd;

  logic [W-1:0]           mem [DEPTH];
  logic [W-1:0]           mem_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [W-1:0]           mem_wd;

  logic [LENW:0]          tbl_mem [SEG_COUNT];
  logic [LENW:0]          tbl_q;
  logic                   tbl_we;
  logic [SIDW-1:0]        tbl_wa, tbl_ra;
  logic [LENW:0]          tbl_wd;

  logic [SIDW-1:0]        fq_mem [SEG_COUNT];
  logic [SIDW-1:0]        fq_q;
  logic                   fq_we;
  logic [SIDW-1:0]        fq_tail;
  logic [CNTW:0]          fq_sum;
  logic [SIDW-1:0]        fq_head_n;

  sumcs_pkg::op_e         op;
  logic [RAW-1:0]         a_idx, b_idx, c_idx;
  logic [W-1:0]           sel_id;
  logic [LENW-1:0]        seg_len;
  logic                   seg_ok;
  logic                   len0_full, pc_ok;
  logic                   map_fromq, map_ok;
  logic [SIDW-1:0]        map_id;
  logic                   load_ok, store_ok, unmap_ok;
  sumcs_pkg::status_e     ex_st;
  sumcs_pkg::nx_e         ex_nx;
  logic [W:0]             dv_t;
  logic                   dv_ge;
  logic [W-1:0]           rem_n, quo_n;
  logic                   loop_last;

  assign op    = sumcs_pkg::op_e'(ir_q[31:28]);
  assign a_idx = ir_q[8:6];
  assign b_idx = ir_q[5:3];
  assign c_idx = ir_q[2:0];

  assign len0_full = len0_q >= LENW'(SEG_WORDS);
  assign pc_ok     = pc_q < len0_q;

  assign sel_id = (op == sumcs_pkg::OP_STORE) ? rf_q0 :
                  (op == sumcs_pkg::OP_UNMAP) ? rc_q : rb_q;

  assign seg_len = sel_is0_q ? len0_q : (sel_vld_q ? tbl_q[LENW-1:0] : '0);
  assign seg_ok  = sel_inr_q && (sel_is0_q || (sel_vld_q && tbl_q[LENW]));

  assign map_fromq = fq_cnt_q != '0;
  assign map_ok    = (rc_q <= W'(SEG_WORDS)) && (map_fromq || (nu_q < CNTW'(SEG_COUNT)));
  assign map_id    = map_fromq ? fq_q : SIDW'(nu_q);

  assign load_ok  = seg_ok && (rc_q < W'(seg_len));
  assign store_ok = seg_ok && (rb_q < W'(seg_len));
  assign unmap_ok = (rc_q != '0) && seg_ok;

  assign fq_sum    = (CNTW+1)'(fq_head_q) + (CNTW+1)'(fq_cnt_q);
  assign fq_tail   = (fq_sum >= (CNTW+1)'(SEG_COUNT)) ?
                     SIDW'(fq_sum - (CNTW+1)'(SEG_COUNT)) : SIDW'(fq_sum);
  assign fq_head_n = (fq_head_q == SIDW'(SEG_COUNT - 1)) ? '0 : fq_head_q + 1'b1;

  assign dv_t  = {div_rem_q, div_quo_q[W-1]};
  assign dv_ge = dv_t >= {1'b0, rc_q};
  assign rem_n = dv_ge ? W'(dv_t - {1'b0, rc_q}) : dv_t[W-1:0];
  assign quo_n = {div_quo_q[W-2:0], dv_ge};

  assign loop_last = lp_q == lp_end_q;

  always_comb begin
    ex_st = sumcs_pkg::ST_RUN;
    ex_nx = sumcs_pkg::NX_DONE;
    case (op)
      sumcs_pkg::OP_CMOV, sumcs_pkg::OP_ADD, sumcs_pkg::OP_MUL, sumcs_pkg::OP_NAND,
      sumcs_pkg::OP_OUT, sumcs_pkg::OP_IN, sumcs_pkg::OP_LOADIMM: begin
        ex_nx = sumcs_pkg::NX_DONE;
      end
      sumcs_pkg::OP_LOAD: begin
        if (load_ok) ex_nx = sumcs_pkg::NX_LOAD;
        else ex_st = sumcs_pkg::ST_BAD;
      end
      sumcs_pkg::OP_STORE: begin
        if (!store_ok) ex_st = sumcs_pkg::ST_BAD;
      end
      sumcs_pkg::OP_DIV: begin
        if (rc_q != '0) ex_nx = sumcs_pkg::NX_DIV;
        else ex_st = sumcs_pkg::ST_DIV0;
      end
      sumcs_pkg::OP_HALT: begin
        ex_st = sumcs_pkg::ST_HALT;
      end
      sumcs_pkg::OP_MAP: begin
        if (map_ok) ex_nx = sumcs_pkg::NX_FILL;
        else ex_st = sumcs_pkg::ST_MAPFAIL;
      end
      sumcs_pkg::OP_UNMAP: begin
        if (!unmap_ok) ex_st = sumcs_pkg::ST_BAD;
      end
      sumcs_pkg::OP_LOADPROG: begin
        if (rb_q == '0) ex_nx = sumcs_pkg::NX_JUMP;
        else if (seg_ok) ex_nx = sumcs_pkg::NX_COPY;
        else ex_st = sumcs_pkg::ST_BAD;
      end
      default: begin
        ex_st = sumcs_pkg::ST_BAD;
      end
    endcase
  end

  always_comb begin
    rf_ra0 = '0;
    rf_ra1 = '0;
    rf_we  = 1'b0;
    rf_wa  = '0;
    rf_wd  = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    tbl_we = 1'b0;
    tbl_wa = '0;
    tbl_wd = '0;
    tbl_ra = '0;
    fq_we  = 1'b0;
    case (cmd_i)
      sumcs_pkg::CMD_START: begin
        if (status_q == sumcs_pkg::ST_RUN) begin
          if (!mode_q) begin
            if (!len0_full) begin
              mem_we = 1'b1;
              mem_wa = AW'(len0_q);
              mem_wd = pword_q;
            end
          end else if (pc_ok) begin
            mem_re = 1'b1;
            mem_ra = AW'(pc_q);
          end
        end
      end
      sumcs_pkg::CMD_RDBC: begin
        rf_ra0 = mem_q[5:3];
        rf_ra1 = mem_q[2:0];
      end
      sumcs_pkg::CMD_RDA: begin
        rf_ra0 = a_idx;
      end
      sumcs_pkg::CMD_SEG: begin
        tbl_ra = SIDW'(sel_id);
      end
      sumcs_pkg::CMD_EXEC: begin
        case (op)
          sumcs_pkg::OP_CMOV: begin
            rf_we = rc_q != '0;
            rf_wa = a_idx;
            rf_wd = rb_q;
          end
          sumcs_pkg::OP_LOAD: begin
            mem_re = load_ok;
            mem_ra = slot_addr(SIDW'(rb_q), LENW'(rc_q));
          end
          sumcs_pkg::OP_STORE: begin
            mem_we = store_ok;
            mem_wa = slot_addr(SIDW'(ra_q), LENW'(rb_q));
            mem_wd = rc_q;
          end
          sumcs_pkg::OP_ADD: begin
            rf_we = 1'b1;
            rf_wa = a_idx;
            rf_wd = rb_q + rc_q;
          end
          sumcs_pkg::OP_MUL: begin
            rf_we = 1'b1;
            rf_wa = a_idx;
            rf_wd = rb_q * rc_q;
          end
          sumcs_pkg::OP_NAND: begin
            rf_we = 1'b1;
            rf_wa = a_idx;
            rf_wd = ~(rb_q & rc_q);
          end
          sumcs_pkg::OP_MAP: begin
            if (map_ok) begin
              rf_we  = 1'b1;
              rf_wa  = b_idx;
              rf_wd  = W'(map_id);
              tbl_we = 1'b1;
              tbl_wa = map_id;
              tbl_wd = {1'b1, LENW'(rc_q)};
            end
          end
          sumcs_pkg::OP_UNMAP: begin
            if (unmap_ok) begin
              tbl_we = 1'b1;
              tbl_wa = SIDW'(rc_q);
              tbl_wd = '0;
              fq_we  = 1'b1;
            end
          end
          sumcs_pkg::OP_IN: begin
            rf_we = 1'b1;
            rf_wa = c_idx;
            rf_wd = eof_q ? '1 : W'(inb_q);
          end
          sumcs_pkg::OP_LOADIMM: begin
            rf_we = 1'b1;
            rf_wa = ir_q[27:25];
            rf_wd = W'(ir_q[24:0]);
          end
          default: begin
            rf_we = 1'b0;
          end
        endcase
      end
      sumcs_pkg::CMD_LOAD: begin
        rf_we = 1'b1;
        rf_wa = a_idx;
        rf_wd = mem_q;
      end
      sumcs_pkg::CMD_DIV: begin
        rf_we = div_cnt_q == '1;
        rf_wa = a_idx;
        rf_wd = quo_n;
      end
      sumcs_pkg::CMD_FILL: begin
        mem_we = !loop_last;
        mem_wa = slot_addr(map_id_q, lp_q);
        mem_wd = '0;
      end
      sumcs_pkg::CMD_COPY: begin
        mem_re = !loop_last;
        mem_ra = slot_addr(src_q, lp_q);
        mem_we = lp_q != '0;
        mem_wa = AW'(lp_q - 1'b1);
        mem_wd = mem_q;
      end
      default: begin
        rf_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fq_we) begin
      fq_mem[fq_tail] <= SIDW'(rc_q);
    end
    fq_q <= fq_mem[fq_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    rf_q0 <= rf_vld_q[rf_ra0] ? rf_mem[rf_ra0] : '0;
    rf_q1 <= rf_vld_q[rf_ra1] ? rf_mem[rf_ra1] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= sumcs_pkg::ST_RUN;
      pc_q      <= '0;
      len0_q    <= '0;
      fq_head_q <= '0;
      fq_cnt_q  <= '0;
      nu_q      <= CNTW'(1);
      rf_vld_q  <= '0;
      out_vld_q <= 1'b0;
      emit_q    <= 1'b0;
      taken_q   <= 1'b0;
      div_cnt_q <= '0;
      lp_q      <= '0;
      lp_end_q  <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
      if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i)
        sumcs_pkg::CMD_ACCEPT: begin
          emit_q  <= 1'b0;
          taken_q <= 1'b0;
        end
        sumcs_pkg::CMD_START: begin
          if (status_q == sumcs_pkg::ST_RUN) begin
            if (!mode_q) begin
              if (len0_full) status_q <= sumcs_pkg::ST_OVERFLOW;
              else len0_q <= len0_q + 1'b1;
            end else if (!pc_ok) begin
              status_q <= sumcs_pkg::ST_BAD;
            end else begin
              pc_q <= pc_q + 1'b1;
            end
          end
        end
        sumcs_pkg::CMD_EXEC: begin
          if (ex_st != sumcs_pkg::ST_RUN) begin
            status_q <= ex_st;
          end
          case (op)
            sumcs_pkg::OP_DIV: begin
              div_cnt_q <= '0;
            end
            sumcs_pkg::OP_MAP: begin
              if (map_ok) begin
                if (map_fromq) begin
                  fq_head_q <= fq_head_n;
                  fq_cnt_q  <= fq_cnt_q - 1'b1;
                end else begin
                  nu_q <= nu_q + 1'b1;
                end
                lp_q     <= '0;
                lp_end_q <= LENW'(rc_q);
              end
            end
            sumcs_pkg::OP_UNMAP: begin
              if (unmap_ok) fq_cnt_q <= fq_cnt_q + 1'b1;
            end
            sumcs_pkg::OP_OUT: begin
              emit_q <= 1'b1;
            end
            sumcs_pkg::OP_IN: begin
              taken_q <= 1'b1;
            end
            sumcs_pkg::OP_LOADPROG: begin
              if (rb_q != '0 && seg_ok) begin
                lp_q     <= '0;
                lp_end_q <= seg_len;
                len0_q   <= seg_len;
              end
            end
            default: begin
              emit_q <= emit_q;
            end
          endcase
        end
        sumcs_pkg::CMD_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
        end
        sumcs_pkg::CMD_FILL, sumcs_pkg::CMD_COPY: begin
          if (!loop_last) lp_q <= lp_q + 1'b1;
        end
        sumcs_pkg::CMD_JUMP: begin
          if (rc_q < W'(len0_q)) pc_q <= LENW'(rc_q);
          else status_q <= sumcs_pkg::ST_BAD;
        end
        sumcs_pkg::CMD_EMIT: begin
          out_vld_q <= 1'b1;
        end
        default: begin
          out_vld_q <= out_vld_q & ~out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      sumcs_pkg::CMD_ACCEPT: begin
        mode_q  <= in_mode_i;
        pword_q <= in_word_i;
        inb_q   <= in_byte_i;
        eof_q   <= in_eof_i;
      end
      sumcs_pkg::CMD_RDBC: begin
        ir_q <= mem_q;
      end
      sumcs_pkg::CMD_RDA: begin
        rb_q <= rf_q0;
        rc_q <= rf_q1;
      end
      sumcs_pkg::CMD_SEG: begin
        ra_q      <= rf_q0;
        sel_is0_q <= sel_id == '0;
        sel_inr_q <= sel_id < W'(SEG_COUNT);
        sel_vld_q <= sel_id < W'(nu_q);
      end
      sumcs_pkg::CMD_EXEC: begin
        obyte_q   <= rc_q[7:0];
        div_rem_q <= '0;
        div_quo_q <= rb_q;
        map_id_q  <= map_id;
        src_q     <= SIDW'(rb_q);
      end
      sumcs_pkg::CMD_DIV: begin
        div_rem_q <= rem_n;
        div_quo_q <= quo_n;
      end
      sumcs_pkg::CMD_EMIT: begin
        out_data_q <= {sumcs_pkg::NEXT_PC_W'(pc_q), status_q, taken_q,
                       emit_q ? obyte_q : 8'h00, emit_q};
      end
      default: begin
        mode_q <= mode_q;
      end
    endcase
  end

  assign stat_o.start_run = (status_q == sumcs_pkg::ST_RUN) && mode_q && pc_ok;
  assign stat_o.exec_next = ex_nx;
  assign stat_o.loop_last = loop_last;
  assign stat_o.div_last  = div_cnt_q == '1;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != sumcs_pkg::ST_RUN |=> $stable(status_q))
    else $error("status left a stopped state");

  a_len0_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len0_q <= LENW'(SEG_WORDS))
    else $error("segment 0 length beyond its slot");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_cnt_q < nu_q && nu_q <= CNTW'(SEG_COUNT))
    else $error("free id bookkeeping out of range");

  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i != sumcs_pkg::CMD_START && cmd_i != sumcs_pkg::CMD_JUMP) |=> $stable(pc_q))
    else $error("pc changed outside fetch or jump");

endmodule

`default_nettype wire
